FILE: rtl/acquisition_command_controller_unit_macros.svh
// ----------------------------------------------------------------------------
// acquisition command controller assertion macros
// shared assertion forms used by the checker, clocked on clock
// ----------------------------------------------------------------------------
`ifndef ACQUISITION_COMMAND_CONTROLLER_UNIT_MACROS_SVH
`define ACQUISITION_COMMAND_CONTROLLER_UNIT_MACROS_SVH

// property checked outside reset
`define ACQCMD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property checked also while reset is asserted
`define ACQCMD_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/acqcmd_pkg.sv
// ----------------------------------------------------------------------------
// acquisition command controller package
// transaction types, mode encoding, command and reply codes
// ----------------------------------------------------------------------------
package acqcmd_pkg;

   localparam int SAMPLE_BITS = 10;
   localparam int TIMER_BITS  = 16;
   localparam int CODE_BITS   = 5;

   localparam logic [TIMER_BITS-1:0] BASE_PERIOD_RESET = 16'd1024;
   localparam logic [TIMER_BITS-1:0] ELAPSED_MAX       = 16'hFFFF;

   // command codes
   localparam logic [CODE_BITS-1:0] CMD_HELLO      = 5'd0;
   localparam logic [CODE_BITS-1:0] CMD_CFG_START  = 5'd1;
   localparam logic [CODE_BITS-1:0] CMD_ACQUIRE    = 5'd2;
   localparam logic [CODE_BITS-1:0] CMD_STOP       = 5'd3;
   localparam logic [CODE_BITS-1:0] CMD_CHAN_FIRST = 5'd4;
   localparam logic [CODE_BITS-1:0] CMD_CHAN_LAST  = 5'd9;
   localparam logic [CODE_BITS-1:0] CMD_RATE_FIRST = 5'd10;
   localparam logic [CODE_BITS-1:0] CMD_CFG_END    = 5'd17;

   // reply codes
   localparam logic [1:0] REPLY_OK   = 2'd0;
   localparam logic [1:0] REPLY_NOK  = 2'd1;
   localparam logic [1:0] REPLY_BUSY = 2'd2;

   // result kinds
   localparam logic KIND_REPLY = 1'b0;
   localparam logic KIND_DATA  = 1'b1;

   typedef enum logic [2:0] {
      MODE_STANDBY   = 3'd0,
      MODE_CONNECTED = 3'd1,
      MODE_CONFIG    = 3'd2,
      MODE_READY     = 3'd3,
      MODE_ACQUIRE   = 3'd4
   } mode_type;

   typedef struct packed {
      logic                   cmd_valid;
      logic [CODE_BITS-1:0]   cmd_code;
      logic                   tick;
      logic [SAMPLE_BITS-1:0] sample_a;
      logic [SAMPLE_BITS-1:0] sample_b;
      logic [SAMPLE_BITS-1:0] sample_c;
   } req_type;

   typedef struct packed {
      logic                   kind;
      logic [1:0]             reply;
      logic [SAMPLE_BITS-1:0] data_a;
      logic [SAMPLE_BITS-1:0] data_b;
      logic [SAMPLE_BITS-1:0] data_c;
      logic                   last;
   } rsp_type;

   // results produced by one poll, first one goes out first
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage

FILE: rtl/acqcmd_ctrl.sv
// ----------------------------------------------------------------------------
// acquisition command controller mode logic
// holds mode, channel and rate settings, period timer and held samples;
// turns one accepted poll into up to two results
// ----------------------------------------------------------------------------
module acqcmd_ctrl #(
   parameter int RATE_COUNT = 7
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  acqcmd_pkg::req_type                 req,
   input  logic [acqcmd_pkg::TIMER_BITS-1:0]   base_period,
   output acqcmd_pkg::push_type                push
);
   import acqcmd_pkg::*;

   localparam logic [CODE_BITS:0] RATE_END = (CODE_BITS+1)'(32'(CMD_RATE_FIRST) + RATE_COUNT);

   mode_type               mode_ff, mode_in;
   logic [2:0]             chan_ff, chan_in;
   logic [2:0]             rate_ff, rate_in;
   logic                   running_ff, running_in;
   logic [TIMER_BITS-1:0]  elapsed_ff, elapsed_in;
   logic [SAMPLE_BITS-1:0] held_a_ff, held_a_in;
   logic [SAMPLE_BITS-1:0] held_b_ff, held_b_in;
   logic [SAMPLE_BITS-1:0] held_c_ff, held_c_in;

   logic [2:0]             shift;
   logic [TIMER_BITS-1:0]  period_raw;
   logic [TIMER_BITS-1:0]  period;
   logic [TIMER_BITS-1:0]  elapsed_next;
   logic [CODE_BITS-1:0]   chan_offs;
   logic [CODE_BITS-1:0]   rate_offs;
   logic                   is_chan;
   logic                   is_rate;
   logic                   fire;
   logic                   has_reply;
   logic [1:0]             reply_code;
   rsp_type                packet;
   rsp_type                answer;

   // packet period for the chosen rate, never below one
   always_comb begin
      shift      = (rate_ff == 3'd0) ? 3'd0 : rate_ff - 3'd1;
      period_raw = base_period >> shift;
      period     = (period_raw == '0) ? TIMER_BITS'(1) : period_raw;
   end

   // command decode helpers
   always_comb begin
      chan_offs = req.cmd_code - CMD_CHAN_FIRST;
      rate_offs = req.cmd_code - CMD_RATE_FIRST;
      is_chan   = (req.cmd_code >= CMD_CHAN_FIRST) && (req.cmd_code <= CMD_CHAN_LAST);
      is_rate   = (req.cmd_code >= CMD_RATE_FIRST) && ({1'b0, req.cmd_code} < RATE_END);
      elapsed_next = (req.tick && (elapsed_ff != ELAPSED_MAX)) ? elapsed_ff + 1'b1
                                                               : elapsed_ff;
   end

   // next state and results for one poll
   always_comb begin
      mode_in    = mode_ff;
      chan_in    = chan_ff;
      rate_in    = rate_ff;
      running_in = running_ff;
      elapsed_in = elapsed_ff;
      held_a_in  = held_a_ff;
      held_b_in  = held_b_ff;
      held_c_in  = held_c_ff;
      fire       = 1'b0;
      has_reply  = req.cmd_valid;
      reply_code = REPLY_NOK;
      case (mode_ff)
         MODE_STANDBY: begin
            if (req.cmd_valid && req.cmd_code == CMD_HELLO) begin
               mode_in    = MODE_CONNECTED;
               reply_code = REPLY_OK;
            end
         end
         MODE_CONNECTED: begin
            // ready check comes before the command
            if (rate_ff != 3'd0 && chan_ff != 3'd0) begin
               mode_in = MODE_READY;
            end
            if (req.cmd_valid && req.cmd_code == CMD_CFG_START) begin
               mode_in    = MODE_CONFIG;
               reply_code = REPLY_OK;
            end
         end
         MODE_CONFIG: begin
            if (req.cmd_valid) begin
               if (is_chan) begin
                  chan_in[chan_offs[2:1]] = req.cmd_code[0];
                  reply_code = REPLY_OK;
               end else if (is_rate) begin
                  rate_in    = rate_offs[2:0] + 3'd1;
                  running_in = 1'b0;
                  elapsed_in = '0;
                  reply_code = REPLY_OK;
               end else if (req.cmd_code == CMD_CFG_END) begin
                  mode_in    = MODE_CONNECTED;
                  reply_code = REPLY_OK;
               end
            end
         end
         MODE_READY: begin
            if (req.cmd_valid && req.cmd_code == CMD_CFG_START) begin
               mode_in    = MODE_CONFIG;
               reply_code = REPLY_OK;
            end else if (req.cmd_valid && req.cmd_code == CMD_ACQUIRE) begin
               mode_in    = MODE_ACQUIRE;
               reply_code = REPLY_OK;
            end
         end
         MODE_ACQUIRE: begin
            // period timer: a stopped timer restarts and skips this tick
            if (!running_ff) begin
               running_in = 1'b1;
               elapsed_in = '0;
            end else begin
               elapsed_in = elapsed_next;
               if (elapsed_next >= period) begin
                  fire       = 1'b1;
                  running_in = 1'b0;
               end
            end
            if (fire) begin
               if (chan_ff[0]) held_a_in = req.sample_a;
               if (chan_ff[1]) held_b_in = req.sample_b;
               if (chan_ff[2]) held_c_in = req.sample_c;
            end
            reply_code = REPLY_BUSY;
            if (req.cmd_valid && req.cmd_code == CMD_STOP) begin
               mode_in   = MODE_READY;
               has_reply = 1'b0;
            end
         end
         default: begin
            has_reply = 1'b0;
         end
      endcase
   end

   // result assembly: packet first, then reply
   always_comb begin
      packet.kind   = KIND_DATA;
      packet.reply  = REPLY_OK;
      packet.data_a = held_a_in;
      packet.data_b = held_b_in;
      packet.data_c = held_c_in;
      packet.last   = !has_reply;

      answer.kind   = KIND_REPLY;
      answer.reply  = reply_code;
      answer.data_a = '0;
      answer.data_b = '0;
      answer.data_c = '0;
      answer.last   = 1'b1;

      push.count  = 2'(fire) + 2'(has_reply);
      push.first  = fire ? packet : answer;
      push.second = answer;
   end

   // state registers, updated per accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_STANDBY;
         chan_ff    <= '0;
         rate_ff    <= '0;
         running_ff <= 1'b0;
         elapsed_ff <= '0;
         held_a_ff  <= '0;
         held_b_ff  <= '0;
         held_c_ff  <= '0;
      end else if (accept) begin
         mode_ff    <= mode_in;
         chan_ff    <= chan_in;
         rate_ff    <= rate_in;
         running_ff <= running_in;
         elapsed_ff <= elapsed_in;
         held_a_ff  <= held_a_in;
         held_b_ff  <= held_b_in;
         held_c_ff  <= held_c_in;
      end
   end

endmodule

FILE: rtl/acqcmd_outq.sv
// ----------------------------------------------------------------------------
// acquisition command controller result queue
// four-entry shifting queue; takes up to two results per cycle while room is
// high; the head drives the result channel
// ----------------------------------------------------------------------------
module acqcmd_outq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_en,
   input  acqcmd_pkg::push_type push,
   output logic                 room,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output acqcmd_pkg::rsp_type  rsp_payload
);
   import acqcmd_pkg::*;

   localparam int DEPTH = 4;

   rsp_type    entry_ff [DEPTH];
   rsp_type    entry_in [DEPTH];
   logic [2:0] count_ff, count_in;
   logic       pop;
   logic [2:0] base;
   logic [1:0] added;

   // room for a full pair regardless of the output side
   assign room        = (count_ff <= 3'd2);
   assign rsp_valid   = (count_ff != 3'd0);
   assign rsp_payload = entry_ff[0];
   assign pop         = rsp_valid && !rsp_stall;

   // shift on pop, then append new results behind the survivors
   always_comb begin
      base  = count_ff - 3'(pop);
      added = push_en ? push.count : 2'd0;
      for (int i = 0; i < DEPTH; i++) begin
         if (pop && i < DEPTH - 1) begin
            entry_in[i] = entry_ff[i+1];
         end else begin
            entry_in[i] = entry_ff[i];
         end
         if (added != 2'd0 && 3'(i) == base) begin
            entry_in[i] = push.first;
         end
         if (added == 2'd2 && 3'(i) == base + 3'd1) begin
            entry_in[i] = push.second;
         end
      end
      count_in = base + 3'(added);
   end

   // occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // payload storage
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

FILE: rtl/acquisition_command_controller_unit.sv
// ----------------------------------------------------------------------------
// acquisition command controller
// five-mode command controller with tick-driven packet timer
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one poll per transaction (optional command, tick, three samples)
//   rsp_*  : results, one per transaction; a poll gives zero, one or two
//            results (data packet, then reply); last marks the final one
//   csr_*  : base_period write, only while the block is idle
// Results: an accepted poll's results are written into the result queue
//   registers; with the queue ahead of it empty the first drives rsp from
//   there, and a second result follows once the first is taken.
// Throughput: one poll per cycle; the four-entry result queue sets the pace,
//   and a poll is taken whenever it holds at most two results.
// Reset: synchronous; clears mode to standby, settings, timer, held samples
//   and the queue; base_period returns to 1024.
// Stall: while rsp_stall is high the head result holds; the queue fills and
//   req_stall rises once fewer than two entries are free.
// ----------------------------------------------------------------------------
module acquisition_command_controller_unit #(
   parameter int RATE_COUNT = 7
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  acqcmd_pkg::req_type                 req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output acqcmd_pkg::rsp_type                 rsp_payload,
   input  logic                                csr_write_enable,
   input  logic [acqcmd_pkg::TIMER_BITS-1:0]   csr_write_data
);
   import acqcmd_pkg::*;

   logic [TIMER_BITS-1:0] base_period_ff;
   logic                  room;
   logic                  accept;
   push_type              push;

   assign req_stall = !room;
   assign accept    = req_valid && room;

   // base period register
   always_ff @(posedge clock) begin
      if (reset) begin
         base_period_ff <= BASE_PERIOD_RESET;
      end else if (csr_write_enable) begin
         base_period_ff <= csr_write_data;
      end
   end

   // mode logic
   acqcmd_ctrl #(
      .RATE_COUNT (RATE_COUNT)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req         (req_payload),
      .base_period (base_period_ff),
      .push        (push)
   );

   // result queue
   acqcmd_outq u_outq (
      .clock       (clock),
      .reset       (reset),
      .push_en     (accept),
      .push        (push),
      .room        (room),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: rtl/acqcmd_checker.sv
// ----------------------------------------------------------------------------
// acquisition command controller checker
// port-level properties of the result channel, bound to the top level
// ----------------------------------------------------------------------------
`include "acquisition_command_controller_unit_macros.svh"

module acqcmd_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input acqcmd_pkg::rsp_type rsp_payload
);
   import acqcmd_pkg::*;

   logic rsp_take;
   logic reply_known;
   assign rsp_take    = rsp_valid && !rsp_stall;
   assign reply_known = (rsp_payload.reply == REPLY_OK) || (rsp_payload.reply == REPLY_NOK) ||
                        (rsp_payload.reply == REPLY_BUSY);

   // no result right after reset
   `ACQCMD_ASSERT_RST(a_reset_empty, reset |=> !rsp_valid, "result valid after reset")

   // stalled result holds
   `ACQCMD_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload), "stalled result changed")

   // a packet that is not last is followed at once by a busy reply
   `ACQCMD_ASSERT(a_pkt_then_busy, rsp_take && rsp_payload.kind == KIND_DATA && !rsp_payload.last |=> rsp_valid && rsp_payload.kind == KIND_REPLY && rsp_payload.reply == REPLY_BUSY, "packet not followed by busy")

   // a reply always closes its poll and carries a known code
   `ACQCMD_ASSERT(a_reply_last, rsp_valid && rsp_payload.kind == KIND_REPLY |-> rsp_payload.last && reply_known, "reply not last or bad code")

   // input stalls only while results are waiting
   `ACQCMD_ASSERT(a_stall_backed, req_stall |-> rsp_valid, "input stalled with no result waiting")

endmodule

bind acquisition_command_controller_unit acqcmd_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
